// ===== rtl/mtg_pkg.sv =====
// shared constants, types and functions of the mt19937 word generator
// no dependencies
package mtg_pkg;

    localparam int STATE_WORDS = 624;
    localparam int MID_OFFSET  = 397;
    localparam int KEY_WORDS   = 16;

    localparam int POS_W     = $clog2(STATE_WORDS);
    localparam int KEY_IDX_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int KEY_CNT_W = $clog2(KEY_WORDS + 1);

    localparam logic [31:0] TWIST_XOR    = 32'h9908b0df;
    localparam logic [31:0] TOP_BIT      = 32'h80000000;
    localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] MIX_MULT_A   = 32'd1664525;
    localparam logic [31:0] MIX_MULT_B   = 32'd1566083941;
    localparam logic [31:0] ARRAY_SEED   = 32'd19650218;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(STATE_WORDS - 1);
    localparam logic [POS_W-1:0] MIX2_LAST = POS_W'(STATE_WORDS - 2);

    typedef logic [31:0] word_t;

    // item actions
    typedef enum logic [1:0] {
        ACT_GENERATE = 2'd0,
        ACT_SEED     = 2'd1,
        ACT_KEY      = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // taps of the cell row
    typedef struct packed {
        word_t head;
        word_t second;
        word_t mid;
        word_t tail;
    } taps_t;

    // output tempering
    function automatic word_t temper(input word_t x);
        word_t y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // twist recurrence on the three tapped words
    function automatic word_t twist(input word_t w0, input word_t w1, input word_t wm);
        word_t y;
        y = (w0 & TOP_BIT) | (w1 & LOW_BITS);
        return wm ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    endfunction

endpackage

// ===== rtl/mtg_cell.sv =====
// one state word of the generator, handed on to its neighbour on each shift
// depends on mtg_pkg
module mtg_cell (
    input  logic          clk,
    input  logic          shift_en,
    input  mtg_pkg::word_t word_in,
    output mtg_pkg::word_t word_out
);
    import mtg_pkg::*;

    word_t word_reg;

    // load from the neighbour
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            word_reg <= word_in;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== rtl/mtg_chain.sv =====
// row of state cells; a new word enters at the tail and every word moves one
// cell towards the head on a shift. depends on mtg_pkg and mtg_cell
module mtg_chain (
    input  logic           clk,
    input  logic           shift_en,
    input  mtg_pkg::word_t tail_in,
    output mtg_pkg::taps_t taps
);
    import mtg_pkg::*;

    word_t link [STATE_WORDS];

    // cell k takes the word of cell k+1, the last one takes the new word
    genvar k;
    generate
        for (k = 0; k < STATE_WORDS; k++)
        begin : g_cell
            if (k == STATE_WORDS - 1)
            begin : g_tail
                mtg_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .word_in  (tail_in),
                    .word_out (link[k])
                );
            end
            else
            begin : g_body
                mtg_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .word_in  (link[k+1]),
                    .word_out (link[k])
                );
            end
        end
    endgenerate

    assign taps.head   = link[0];
    assign taps.second = link[1];
    assign taps.mid    = link[MID_OFFSET];
    assign taps.tail   = link[STATE_WORDS-1];

endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// mt19937 32-bit word generator: sequencer, key store and output register
// around a row of 624 state cells. depends on mtg_pkg and mtg_chain
// a generate transfer gives its word from the output register in the next cycle; one
// word per cycle when seeded and the output is not stalled. the first generate after
// reset first seeds with the default seed. scalar seed: one seeding loop over the
// cell row. array seed: scalar seeding, then the rotate, mix1, mix2 and align steps.
// reset clears control and key count; state words are undefined until seeded.
module mersenne_twister_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [1:0] action, [33:2] value, [39:34] zero
    input  logic        s_axis_tlast,  // last key word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [31:0] random_word
);
    import mtg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCALAR = 3'd1;
    localparam logic [2:0] ST_ROT    = 3'd2;
    localparam logic [2:0] ST_MIX1   = 3'd3;
    localparam logic [2:0] ST_MIX2   = 3'd4;
    localparam logic [2:0] ST_ALIGN  = 3'd5;
    localparam logic [2:0] ST_GEN    = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [POS_W-1:0]     cnt_reg, cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [KEY_IDX_W-1:0] j_reg, j_next;
    logic [KEY_CNT_W-1:0] key_count_reg, key_count_next;
    logic                 seeded_reg, seeded_next;
    logic                 array_reg, array_next;
    logic                 gen_pend_reg, gen_pend_next;
    logic                 forced_reg, forced_next;
    logic                 out_valid_reg, out_valid_next;
    word_t                out_data_reg, out_data_next;
    word_t                seed_reg, seed_next;
    word_t                key_store [KEY_WORDS];

    action_t in_action;
    word_t   in_value;
    logic    in_xfer;
    logic    out_free;
    logic    shift_en;
    word_t   tail_in;
    taps_t   taps;
    word_t   mul_a, mul_b, mul_lo;
    word_t   twist_word;
    word_t   key_word;
    logic    key_wr;
    logic    j_wrap;

    assign in_action = action_t'(s_axis_tdata[1:0]);
    assign in_value  = s_axis_tdata[33:2];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // shared multiplier on the tail word
    assign mul_a  = taps.tail ^ (taps.tail >> 30);
    assign mul_lo = mul_a * mul_b;

    assign twist_word = twist(taps.head, taps.second, taps.mid);
    assign key_word   = key_store[j_reg];
    assign j_wrap     = (KEY_CNT_W'(j_reg) + 1'b1) == key_count_reg;

    // state cells
    mtg_chain u_chain (
        .clk      (clk),
        .shift_en (shift_en),
        .tail_in  (tail_in),
        .taps     (taps)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        key_count_next = key_count_reg;
        seeded_next    = seeded_reg;
        array_next     = array_reg;
        gen_pend_next  = gen_pend_reg;
        forced_next    = forced_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        shift_en       = 1'b0;
        tail_in        = twist_word;
        mul_b          = SEED_MULT;
        key_wr         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (in_action)
                        ACT_GENERATE:
                        begin
                            if (seeded_reg)
                            begin
                                shift_en       = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = temper(twist_word);
                            end
                            else
                            begin
                                seed_next     = DEFAULT_SEED;
                                array_next    = 1'b0;
                                gen_pend_next = 1'b1;
                                cnt_next      = '0;
                                state_next    = ST_SCALAR;
                            end
                        end
                        ACT_SEED:
                        begin
                            seed_next     = in_value;
                            array_next    = 1'b0;
                            gen_pend_next = 1'b0;
                            cnt_next      = '0;
                            state_next    = ST_SCALAR;
                        end
                        ACT_KEY:
                        begin
                            if (key_count_reg < KEY_CNT_W'(KEY_WORDS))
                            begin
                                key_wr         = 1'b1;
                                key_count_next = key_count_reg + 1'b1;
                            end
                            if (s_axis_tlast)
                            begin
                                seed_next     = ARRAY_SEED;
                                array_next    = 1'b1;
                                gen_pend_next = 1'b0;
                                cnt_next      = '0;
                                state_next    = ST_SCALAR;
                            end
                        end
                        ACT_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCALAR:
            begin
                shift_en = 1'b1;
                mul_b    = SEED_MULT;
                tail_in  = (cnt_reg == '0) ? seed_reg : mul_lo + 32'(cnt_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_POS)
                begin
                    pos_next    = '0;
                    cnt_next    = '0;
                    seeded_next = 1'b1;
                    if (array_reg)
                    begin
                        state_next = ST_ROT;
                    end
                    else if (gen_pend_reg)
                    begin
                        state_next = ST_GEN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROT:
            begin
                // start mixing at word 1
                shift_en   = 1'b1;
                tail_in    = taps.head;
                pos_next   = pos_reg + 1'b1;
                j_next     = '0;
                state_next = ST_MIX1;
            end
            ST_MIX1:
            begin
                shift_en = 1'b1;
                mul_b    = MIX_MULT_A;
                pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                if (pos_reg == '0)
                begin
                    // word 0 takes a copy of the last word
                    tail_in = taps.tail;
                end
                else
                begin
                    tail_in  = (taps.head ^ mul_lo) + key_word + 32'(j_reg);
                    j_next   = j_wrap ? '0 : j_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_POS)
                    begin
                        cnt_next   = '0;
                        state_next = ST_MIX2;
                    end
                end
            end
            ST_MIX2:
            begin
                shift_en = 1'b1;
                mul_b    = MIX_MULT_B;
                pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                if (pos_reg == '0)
                begin
                    tail_in = taps.tail;
                end
                else
                begin
                    tail_in  = (taps.head ^ mul_lo) - 32'(pos_reg);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == MIX2_LAST)
                    begin
                        cnt_next    = '0;
                        forced_next = 1'b0;
                        state_next  = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                // rotate word 0 back to the head, forcing it on the way
                shift_en = 1'b1;
                pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                if (pos_reg == '0)
                begin
                    tail_in     = TOP_BIT;
                    forced_next = 1'b1;
                end
                else
                begin
                    tail_in = taps.head;
                end
                if (pos_reg == LAST_POS && forced_reg)
                begin
                    key_count_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_GEN:
            begin
                if (out_free)
                begin
                    shift_en       = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = temper(twist_word);
                    gen_pend_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
            seeded_reg    <= 1'b0;
            array_reg     <= 1'b0;
            gen_pend_reg  <= 1'b0;
            forced_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
            seeded_reg    <= seeded_next;
            array_reg     <= array_next;
            gen_pend_reg  <= gen_pend_next;
            forced_reg    <= forced_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        seed_reg     <= seed_next;
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_store[key_count_reg[KEY_IDX_W-1:0]] <= in_value;
        end
    end

    // checks
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> pos_reg == '0)
        else $error("cell row not aligned in idle");

    a_key_cap: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_CNT_W'(KEY_WORDS))
        else $error("key count past store size");

    a_gen_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GEN |-> seeded_reg && gen_pend_reg)
        else $error("generate pending without seeding");

    a_mix_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIX1) |-> (key_count_reg != '0)
            && (KEY_CNT_W'(j_reg) < key_count_reg))
        else $error("key index outside stored key");

endmodule
